### design/robin_hood_hash_set_unit_assert.svh
// Assertion macros for the Robin Hood hash set unit checker
`ifndef ROBIN_HOOD_HASH_SET_UNIT_ASSERT_SVH
`define ROBIN_HOOD_HASH_SET_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define RHH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define RHH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rhh_pkg.sv
// Shared types and constants of the Robin Hood hash set unit
`default_nettype none
package rhh_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned HASH_W    = 32;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned ACT_W     = 2;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd57;

  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

  typedef struct packed {
    logic                mod_step;
    logic                probe_start;
    logic                rd_pos;
    logic                rd_next;
    logic                rd_prev;
    logic                probe_adv;
    logic                scan_init;
    logic                scan_adv;
    logic                wr_shift;
    logic                wr_new;
    logic                wr_close;
    logic                close_init;
    logic                close_end;
    logic                clear_all;
    logic                set_res;
    logic [STATUS_W-1:0] res;
    logic                publish;
  } rhh_cmd_t;

  typedef struct packed {
    logic mod_last;
    logic is_add;
    logic is_remove;
    logic is_clear;
    logic pv;
    logic hit;
    logic richer;
    logic last;
    logic full;
    logic e_free;
    logic e_done;
    logic close_stop;
    logic out_busy;
  } rhh_sts_t;

endpackage
`default_nettype wire

### design/rhh_dp.sv
// Datapath: request registers, hash reduction, slot memory, valid bits, result register
`default_nettype none
module rhh_dp import rhh_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_fire,
  input  wire logic [ACT_W-1:0]    action,
  input  wire logic [HASH_W-1:0]   hash,
  input  wire logic [KEY_W-1:0]    key,
  input  wire logic [KEY_W-1:0]    fallback,
  input  wire logic                load_limit_we,
  input  wire logic [COUNT_W-1:0]  load_limit_data,
  input  wire logic                out_ready,
  input  wire rhh_cmd_t            cmd,
  output rhh_sts_t                 sts,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      status,
  output logic [KEY_W-1:0]         key_out,
  output logic [COUNT_W-1:0]       item_count,
  output logic                     over_limit
);

  localparam int unsigned IW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned DW   = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned CW   = DW;
  localparam int unsigned EW   = IW + HASH_W + KEY_W;
  localparam int unsigned CMPW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned SH   = HASH_W + IW;
  localparam int unsigned PW   = 2 * HASH_W + 1;
  localparam logic [IW:0]   NUM     = (IW+1)'(TABLE_SLOTS);
  localparam logic [IW-1:0] TOP_IDX = IW'(TABLE_SLOTS - 1);
  localparam logic [HASH_W-1:0] NUM_H = HASH_W'(TABLE_SLOTS);
  // floor(2^SH / slots): the quotient estimate is low by at most one
  localparam logic [HASH_W:0] RECIP = (HASH_W+1)'((64'd1 << SH) / 64'(TABLE_SLOTS));

  logic [ACT_W-1:0]  act;
  logic [HASH_W-1:0] req_hash;
  logic [KEY_W-1:0]  req_key;
  logic [KEY_W-1:0]  req_fb;
  logic [IW-1:0]     rem;
  logic [1:0]        mod_cnt;
  logic [PW-1:0]     mod_prod;
  logic [HASH_W-1:0] mod_qn;
  logic [IW-1:0]     pos;
  logic [IW-1:0]     e;
  logic [DW-1:0]     d;
  logic [CW-1:0]     cnt;
  logic [COUNT_W-1:0] load_limit;
  logic [TABLE_SLOTS-1:0] slot_valid;
  logic [EW-1:0]     mem [TABLE_SLOTS];
  logic [EW-1:0]     rd_data;
  logic [STATUS_W-1:0] res_status;
  logic [KEY_W-1:0]  res_key;

  logic [HASH_W-1:0] mod_q;
  logic [HASH_W-1:0] mod_diff;
  logic [IW:0]       mod_low;
  logic [IW-1:0]     pos_nxt;
  logic [IW-1:0]     e_nxt;
  logic [IW-1:0]     e_prv;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     rd_home;
  logic [HASH_W-1:0] rd_hash;
  logic [KEY_W-1:0]  rd_key;
  logic [IW:0]       rd_dist;
  logic              rd_en;

  assign mod_q    = HASH_W'(mod_prod >> SH);
  assign mod_diff = req_hash - mod_qn;
  // remainder estimate is below twice the slot count
  assign mod_low  = mod_diff[IW:0];
  assign pos_nxt = (pos == TOP_IDX) ? '0 : pos + 1'b1;
  assign e_nxt   = (e == TOP_IDX) ? '0 : e + 1'b1;
  assign e_prv   = (e == '0) ? TOP_IDX : e - 1'b1;
  assign {rd_home, rd_hash, rd_key} = rd_data;
  // distance of the stored entry from its home, wrapping at the table end
  assign rd_dist = (pos >= rd_home) ? {1'b0, pos - rd_home}
                                    : {1'b0, pos} + NUM - {1'b0, rd_home};

  always_comb begin
    rd_en   = cmd.rd_pos | cmd.rd_next | cmd.rd_prev;
    rd_addr = pos;
    if (cmd.rd_next) begin
      rd_addr = pos_nxt;
    end else if (cmd.rd_prev) begin
      rd_addr = e_prv;
    end
  end

  always_comb begin
    sts.mod_last   = (mod_cnt == '0);
    sts.is_add     = (act == ACT_ADD);
    sts.is_remove  = (act == ACT_REMOVE);
    sts.is_clear   = (act == ACT_CLEAR);
    sts.pv         = slot_valid[pos];
    sts.hit        = (rd_hash == req_hash) && (rd_key == req_key);
    sts.richer     = rd_dist < (IW+1)'(d);
    sts.last       = (d == DW'(TABLE_SLOTS - 1));
    sts.full       = (cnt == CW'(TABLE_SLOTS));
    sts.e_free     = !slot_valid[e];
    sts.e_done     = (e == pos);
    sts.close_stop = !slot_valid[pos_nxt] || (rd_home == pos_nxt) ||
                     (d == DW'(TABLE_SLOTS));
    sts.out_busy   = out_valid;
  end

  // slot memory, one read and one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.wr_shift) begin
      mem[e] <= rd_data;
    end else if (cmd.wr_close) begin
      mem[pos] <= rd_data;
    end else if (cmd.wr_new) begin
      mem[pos] <= {rem, req_hash, req_key};
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act      <= action;
      req_hash <= hash;
      req_key  <= key;
      req_fb   <= fallback;
      mod_cnt  <= 2'd2;
    end else if (cmd.mod_step) begin
      // three steps: product, quotient times slots, corrected remainder
      mod_prod <= {{(HASH_W+1){1'b0}}, req_hash} * {{HASH_W{1'b0}}, RECIP};
      mod_qn   <= mod_q * NUM_H;
      rem      <= (mod_low >= NUM) ? IW'(mod_low - NUM) : IW'(mod_low);
      mod_cnt  <= mod_cnt - 1'b1;
    end
    if (cmd.probe_start) begin
      pos <= rem;
      d   <= '0;
    end else if (cmd.probe_adv || cmd.wr_close) begin
      pos <= pos_nxt;
      d   <= d + 1'b1;
    end else if (cmd.close_init) begin
      d <= '0;
    end
    if (cmd.scan_init) begin
      e <= pos_nxt;
    end else if (cmd.scan_adv) begin
      e <= e_nxt;
    end else if (cmd.wr_shift) begin
      e <= e_prv;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res;
      case (cmd.res)
        ST_FOUND, ST_REMOVED: res_key <= rd_key;
        ST_MISS:              res_key <= req_fb;
        ST_INSERTED, ST_FULL: res_key <= req_key;
        default:              res_key <= '0;
      endcase
    end
    if (cmd.publish) begin
      status     <= res_status;
      key_out    <= res_key;
      item_count <= COUNT_W'(cnt);
      over_limit <= CMPW'(cnt) > CMPW'(load_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      cnt        <= '0;
      load_limit <= LIMIT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (load_limit_we) begin
        load_limit <= load_limit_data;
      end
      if (cmd.clear_all) begin
        slot_valid <= '0;
        cnt        <= '0;
      end else if (cmd.wr_shift) begin
        slot_valid[e] <= 1'b1;
      end else if (cmd.wr_close) begin
        slot_valid[pos] <= 1'b1;
      end else if (cmd.wr_new) begin
        slot_valid[pos] <= 1'b1;
        cnt             <= cnt + 1'b1;
      end else if (cmd.close_end) begin
        slot_valid[pos] <= 1'b0;
        cnt             <= cnt - 1'b1;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### design/rhh_ctrl.sv
// Controller: sequences hash reduction, probe, run shift up, run pull back, clear and result hand-off
`default_nettype none
module rhh_ctrl import rhh_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rhh_sts_t sts,
  output rhh_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_MOD, S_PSTART, S_PROBE_RD, S_PROBE_EV, S_SCAN,
    S_SHIFT_RD, S_SHIFT_WR, S_INSERT, S_CLOSE_RD, S_CLOSE_EV, S_CLOSE_END,
    S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.is_clear) begin
          cmd.clear_all = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res       = ST_CLEARED;
          state_next    = S_FINISH;
        end else begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = S_PSTART;
        end
      end
      S_PSTART: begin
        cmd.probe_start = 1'b1;
        state_next      = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        cmd.rd_pos = 1'b1;
        state_next = S_PROBE_EV;
      end
      S_PROBE_EV: begin
        if (sts.pv && sts.hit) begin
          cmd.set_res = 1'b1;
          if (sts.is_remove) begin
            cmd.res        = ST_REMOVED;
            cmd.close_init = 1'b1;
            state_next     = S_CLOSE_RD;
          end else begin
            cmd.res    = ST_FOUND;
            state_next = S_FINISH;
          end
        end else if (!sts.pv || sts.richer || sts.last) begin
          if (sts.is_add && !sts.full && !sts.pv) begin
            state_next = S_INSERT;
          end else if (sts.is_add && !sts.full && sts.richer) begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end else begin
            cmd.set_res = 1'b1;
            cmd.res     = sts.is_add ? ST_FULL : ST_MISS;
            state_next  = S_FINISH;
          end
        end else begin
          cmd.probe_adv = 1'b1;
          state_next    = S_PROBE_RD;
        end
      end
      S_SCAN: begin
        if (sts.e_free) begin
          state_next = S_SHIFT_RD;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        if (sts.e_done) begin
          state_next = S_INSERT;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_INSERT: begin
        cmd.wr_new  = 1'b1;
        cmd.set_res = 1'b1;
        cmd.res     = ST_INSERTED;
        state_next  = S_FINISH;
      end
      S_CLOSE_RD: begin
        cmd.rd_next = 1'b1;
        state_next  = S_CLOSE_EV;
      end
      S_CLOSE_EV: begin
        if (sts.close_stop) begin
          state_next = S_CLOSE_END;
        end else begin
          cmd.wr_close = 1'b1;
          state_next   = S_CLOSE_RD;
        end
      end
      S_CLOSE_END: begin
        cmd.close_end = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### design/robin_hood_hash_set_unit.sv
// Robin Hood hash set unit: top level joining controller and datapath.
// One item at a time. The hash is reduced to its home slot by a reciprocal
// multiply and one compare and subtract. Each probed slot is read through
// the single registered read port of the slot memory. An add into an empty
// slot writes the new entry there; one that displaces a run first scans for
// a free slot, then moves each entry of the run up by one slot, reading it
// and then writing it. A remove that hits pulls back the entries after it.
// The result sits in an output register; a finished result waits while the
// previous one is still unaccepted, and the next item is taken once the
// current one has been handed to the register.
// Valid bits live in flops and are cleared at reset, so no clearing pass runs.
`default_nettype none
module robin_hood_hash_set_unit import rhh_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ACT_W-1:0]    action,
  input  wire logic [HASH_W-1:0]   hash,
  input  wire logic [KEY_W-1:0]    key,
  input  wire logic [KEY_W-1:0]    fallback,
  input  wire logic                load_limit_we,
  input  wire logic [COUNT_W-1:0]  load_limit_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      status,
  output logic [KEY_W-1:0]         key_out,
  output logic [COUNT_W-1:0]       item_count,
  output logic                     over_limit
);

  rhh_cmd_t cmd;
  rhh_sts_t sts;
  logic     in_fire;

  assign in_fire = in_valid && in_ready;

  rhh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rhh_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .in_fire         (in_fire),
    .action          (action),
    .hash            (hash),
    .key             (key),
    .fallback        (fallback),
    .load_limit_we   (load_limit_we),
    .load_limit_data (load_limit_data),
    .out_ready       (out_ready),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .status          (status),
    .key_out         (key_out),
    .item_count      (item_count),
    .over_limit      (over_limit)
  );

endmodule
`default_nettype wire

### design/rhh_checker.sv
// Port-level checker for the Robin Hood hash set unit, with its bind
`default_nettype none
`include "robin_hood_hash_set_unit_assert.svh"
module rhh_checker import rhh_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [KEY_W-1:0]    key_out,
  input wire logic [COUNT_W-1:0]  item_count
);

  // a stalled result holds its value
  `RHH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(key_out) && $stable(status), "result changed while stalled")
  // one item in flight at a time
  `RHH_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item accepted while busy")
  // a clear empties the table
  `RHH_ASSERT_NOW(a_clear_empty, out_valid && status == ST_CLEARED, item_count == '0 && key_out == '0, "clear left items")
  // an insert leaves at least one item
  `RHH_ASSERT_NOW(a_insert_count, out_valid && status == ST_INSERTED, item_count != '0, "insert with empty count")

endmodule

bind robin_hood_hash_set_unit rhh_checker u_rhh_checker (.*);
`default_nettype wire

### sim/tb.sv
// Testbench for the Robin Hood hash set unit: directed and random requests
`default_nettype none
module tb import rhh_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 64;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ACT_W-1:0] action = ACT_LOOKUP;
  logic [HASH_W-1:0] hash = '0;
  logic [KEY_W-1:0] key = '0;
  logic [KEY_W-1:0] fallback = '0;
  logic load_limit_we = 1'b0;
  logic [COUNT_W-1:0] load_limit_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0] key_out;
  logic [COUNT_W-1:0] item_count;
  logic over_limit;

  robin_hood_hash_set_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .hash(hash), .key(key), .fallback(fallback),
    .load_limit_we(load_limit_we), .load_limit_data(load_limit_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .key_out(key_out), .item_count(item_count),
    .over_limit(over_limit)
  );

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [KEY_W-1:0] kout;
    logic [COUNT_W-1:0] cnt;
    logic ovl;
  } reply_t;

  // shadow table
  bit tbl_used[NSLOT];
  logic [HASH_W-1:0] tbl_hash[NSLOT];
  logic [KEY_W-1:0] tbl_key[NSLOT];
  int unsigned tbl_count;
  logic [COUNT_W-1:0] limit_shadow;

  reply_t expected_replies[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;  // no idling while set

  // recent keys, reused so lookups and removes hit
  logic [HASH_W-1:0] seen_hash[$];
  logic [KEY_W-1:0] seen_key[$];

  initial forever #5 clk = ~clk;

  function automatic int slot_dist(logic [HASH_W-1:0] h, int k);
    int o;
    o = h % NSLOT;
    return (k >= o) ? k - o : NSLOT - o + k;
  endfunction

  function automatic void move_slot(int from, int to);
    tbl_used[to] = tbl_used[from];
    tbl_hash[to] = tbl_hash[from];
    tbl_key[to] = tbl_key[from];
  endfunction

  function automatic reply_t table_step(logic [ACT_W-1:0] act, logic [HASH_W-1:0] h,
                                        logic [KEY_W-1:0] k, logic [KEY_W-1:0] fb);
    reply_t r;
    int pos, e, last, n;
    int outcome;  // 0 hit, 1 empty, 2 richer, 3 exhausted
    outcome = 3;
    pos = h % NSLOT;
    if (act == ACT_CLEAR) begin
      for (int i = 0; i < NSLOT; i++) tbl_used[i] = 0;
      tbl_count = 0;
      r.st = ST_CLEARED;
      r.kout = '0;
    end else begin
      for (int d = 0; d < NSLOT; d++) begin
        pos = (h % NSLOT + d) % NSLOT;
        if (!tbl_used[pos]) begin outcome = 1; break; end
        if (tbl_hash[pos] == h && tbl_key[pos] == k) begin outcome = 0; break; end
        if (slot_dist(tbl_hash[pos], pos) < d) begin outcome = 2; break; end
      end
      if (outcome == 0) begin
        r.kout = tbl_key[pos];
        if (act == ACT_REMOVE) begin
          tbl_used[pos] = 0;
          if (tbl_count > 0) tbl_count--;
          for (int i = 0; i < NSLOT; i++) begin
            n = (pos + 1) % NSLOT;
            if (!tbl_used[n] || tbl_hash[n] % NSLOT == n) break;
            move_slot(n, pos);
            pos = n;
          end
          tbl_used[pos] = 0;
          r.st = ST_REMOVED;
        end else begin
          r.st = ST_FOUND;
        end
      end else if (act == ACT_ADD) begin
        r.kout = k;
        if (tbl_count >= NSLOT || outcome == 3) begin
          r.st = ST_FULL;
        end else begin
          if (outcome == 2) begin
            e = pos;
            for (int i = 0; i < NSLOT; i++) begin
              e = (e + 1) % NSLOT;
              if (!tbl_used[e]) break;
            end
            while (e != pos) begin
              last = e ? e - 1 : NSLOT - 1;
              move_slot(last, e);
              e = last;
            end
          end
          tbl_used[pos] = 1;
          tbl_hash[pos] = h;
          tbl_key[pos] = k;
          tbl_count++;
          r.st = ST_INSERTED;
        end
      end else begin
        r.st = ST_MISS;
        r.kout = fb;
      end
    end
    r.cnt = tbl_count[COUNT_W-1:0];
    r.ovl = (tbl_count > limit_shadow);
    return r;
  endfunction

  // valid stays up after an accept until the next item or an idle cycle drops it
  task automatic send_request(logic [ACT_W-1:0] act, logic [HASH_W-1:0] h,
                              logic [KEY_W-1:0] k, logic [KEY_W-1:0] fb);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    action <= act;
    hash <= h;
    key <= k;
    fallback <= fb;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_replies.push_back(table_step(act, h, k, fb));
    if (act == ACT_ADD) begin
      seen_hash.push_back(h);
      seen_key.push_back(k);
      if (seen_hash.size() > 80) begin
        void'(seen_hash.pop_front());
        void'(seen_key.pop_front());
      end
    end
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_limit(logic [COUNT_W-1:0] v);
    drain();
    load_limit_data <= v;
    load_limit_we <= 1'b1;
    @(negedge clk);
    load_limit_we <= 1'b0;
    limit_shadow = v;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected item: status %0d key_out %h", status, key_out);
        errors++;
      end else begin
        exp_r = expected_replies.pop_front();
        if (status !== exp_r.st) begin
          $error("status exp %0d got %0d", exp_r.st, status); errors++;
        end
        if (key_out !== exp_r.kout) begin
          $error("key_out exp %h got %h", exp_r.kout, key_out); errors++;
        end
        if (item_count !== exp_r.cnt) begin
          $error("item_count exp %0d got %0d", exp_r.cnt, item_count); errors++;
        end
        if (over_limit !== exp_r.ovl) begin
          $error("over_limit exp %0d got %0d", exp_r.ovl, over_limit); errors++;
        end
      end
    end
  end

  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 21);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("robin_hood_hash_set_unit regression: fail");
      $finish;
    end
  end

  task automatic test_extremes;
    send_request(ACT_LOOKUP, '0, '0, '1);
    send_request(ACT_REMOVE, '1, '1, 64'h0123_4567_89ab_cdef);
    send_request(ACT_ADD, '0, '0, '0);
    send_request(ACT_ADD, '1, '1, '0);
    send_request(ACT_LOOKUP, '1, '1, '0);
    send_request(ACT_ADD, '1, '1, '0);            // present key
    send_request(ACT_LOOKUP, 32'h3f, '1, 64'h5a); // same key, other hash
    send_request(ACT_ADD, 32'h40, 64'h55, '0);    // collides at home 0
    send_request(ACT_ADD, 32'h3e, 64'haa, '0);    // lands in its empty home slot 62
    send_request(ACT_REMOVE, '0, '0, '0);         // pulls back followers
    send_request(ACT_LOOKUP, 32'h40, 64'h55, '0);
    send_request(ACT_CLEAR, '1, '1, '1);
    send_request(ACT_LOOKUP, 32'h40, 64'h55, 64'hdead);
  endtask

  task automatic test_fill_full;
    logic [KEY_W-1:0] k;
    write_limit(7'd0);
    for (int i = 0; i < NSLOT + 3; i++) begin
      k = {$urandom, $urandom};
      send_request(ACT_ADD, $urandom_range(7), k, '0);
    end
    send_request(ACT_LOOKUP, 32'h5, 64'h1, 64'hbeef);
    write_limit(7'd64);
    send_request(ACT_REMOVE, seen_hash[$], seen_key[$], '0);
    send_request(ACT_ADD, 32'h9, 64'h9, '0);
    send_request(ACT_CLEAR, '0, '0, '0);
  endtask

  task automatic test_random(int n, bit tight);
    int p, i;
    logic [HASH_W-1:0] h;
    logic [KEY_W-1:0] k;
    for (int j = 0; j < n; j++) begin
      p = $urandom_range(99);
      h = tight ? $urandom_range(15) * ($urandom_range(1) ? 1 : 65) : $urandom;
      k = $urandom_range(1) ? {$urandom, $urandom} : 64'($urandom_range(7));
      if (p < 45) begin
        send_request(ACT_ADD, h, k, {$urandom, $urandom});
      end else if (seen_hash.size() != 0 && p < 85) begin
        i = $urandom_range(seen_hash.size() - 1);
        send_request((p < 65) ? ACT_LOOKUP : ACT_REMOVE, seen_hash[i], seen_key[i],
                     {$urandom, $urandom});
      end else if (p < 98) begin
        send_request(p[0] ? ACT_LOOKUP : ACT_REMOVE, h, k, {$urandom, $urandom});
      end else begin
        send_request(ACT_CLEAR, h, k, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    limit_shadow = LIMIT_RESET;
    tbl_count = 0;
    for (int i = 0; i < NSLOT; i++) tbl_used[i] = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_extremes();
    test_fill_full();
    write_limit(7'd5);
    test_random(300, 1'b1);
    calm = 1'b1;
    test_random(150, 1'b0);
    calm = 1'b0;
    write_limit(7'd30);
    test_random(350, 1'b1);
    drain();
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("robin_hood_hash_set_unit regression: pass");
    end else begin
      $display("robin_hood_hash_set_unit regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
